>>> rtl/vn2c_pkg.sv
// Shared constants, types and the cosine weight table for the 2D value noise block.
`timescale 1ns / 1ps

package vn2c_pkg;

   // fixed-point formats
   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int WT_BITS   = 10;
   localparam int WT_SIZE   = 1 << WT_BITS;
   localparam int WEIGHT_W  = 17;              // Q0.16 weight, 1.0 included
   localparam int NOISE_W   = 18;              // Q1.16 signed
   localparam int LAT_W     = 31;              // hash only sees the low 31 bits
   localparam int DIFF_W    = NOISE_W + 1;
   localparam int PROD_W    = DIFF_W + WEIGHT_W + 1;
   localparam int BLEND_SHIFT = 16;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
   localparam logic signed [NOISE_W-1:0] NOISE_ONE = NOISE_W'(65536);
   localparam logic signed [PROD_W-1:0] BLEND_ROUND = PROD_W'(32768);

   // corner hash
   localparam logic [LAT_W-1:0] LATTICE_MUL = LAT_W'(57);
   localparam int               HASH_XSHIFT = 13;
   localparam logic [LAT_W-1:0] HASH_MUL    = LAT_W'(60493);
   localparam logic [LAT_W-1:0] HASH_ADD1   = LAT_W'(19990303);
   localparam logic [LAT_W-1:0] HASH_ADD2   = LAT_W'(1376312589);
   localparam int               HASH_SHIFT  = 14;

   // offsets of the four lattice corners from the base hash input
   localparam logic [LAT_W-1:0] OFS_X0Y0 = LAT_W'(0);
   localparam logic [LAT_W-1:0] OFS_X1Y0 = LAT_W'(1);
   localparam logic [LAT_W-1:0] OFS_X0Y1 = LAT_W'(57);
   localparam logic [LAT_W-1:0] OFS_X1Y1 = LAT_W'(58);

   // pipeline stage positions
   localparam int ST_SPLIT   = 0;
   localparam int ST_BASE    = 1;
   localparam int ST_MIX     = 2;
   localparam int ST_SQ      = 3;
   localparam int ST_MUL     = 4;
   localparam int ST_FIN     = 5;
   localparam int ST_VAL     = 6;
   localparam int ST_XPROD   = 7;
   localparam int ST_XBLEND  = 8;
   localparam int ST_YPROD   = 9;
   localparam int ST_OUT     = 10;
   localparam int NUM_STAGES = 11;

   typedef struct packed {
      logic mix;
      logic sq;
      logic mul;
      logic fin;
      logic val;
   } hash_en_type;

   typedef logic [WEIGHT_W-1:0] weight_rom_type [WT_SIZE];

   // sine from a Q30 Taylor series up to the 15th power
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam logic [63:0] PHI_DIV = 64'(2 * WT_SIZE);

   function automatic logic [WEIGHT_W-1:0] small_weight(input logic [63:0] k);
      logic [63:0] phi;
      logic [63:0] phi2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] s2;
      phi  = (PI_Q30 * k) / PHI_DIV;
      phi2 = (phi * phi) >> 30;
      term = ((phi * phi2) >> 30) / 64'd6;
      sum  = phi - term;
      term = ((term * phi2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * phi2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * phi2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * phi2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * phi2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * phi2) >> 30) / 64'd210;
      sum  = sum - term;
      s2   = (sum * sum) >> 30;
      return WEIGHT_W'((s2 + 64'd8192) >> 14);
   endfunction

   // upper half mirrors the lower half around one half
   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      int i;
      for (i = 0; i < WT_SIZE; i++) begin
         if (2 * i <= WT_SIZE)
            rom[i] = small_weight(64'(i));
         else
            rom[i] = WEIGHT_ONE - small_weight(64'(WT_SIZE - i));
      end
      return rom;
   endfunction

   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

   // truncate toward zero: floor, plus one for a negative value with fraction bits
   function automatic logic [LAT_W-1:0] lattice_of(input logic signed [COORD_W-1:0] c);
      logic signed [COORD_W-1:0] fl;
      logic                      up;
      fl = c >>> FRAC_BITS;
      up = c[COORD_W-1] && (|c[FRAC_BITS-1:0]);
      return fl[LAT_W-1:0] + LAT_W'(up);
   endfunction

   // weight index from the fraction magnitude, scaled to the table size
   function automatic logic [WT_BITS-1:0] weight_index(input logic signed [COORD_W-1:0] c);
      logic [FRAC_BITS-1:0]         fr;
      logic [FRAC_BITS+WT_BITS-1:0] wide;
      fr   = c[COORD_W-1] ? (FRAC_BITS'(0) - c[FRAC_BITS-1:0]) : c[FRAC_BITS-1:0];
      wide = {fr, {WT_BITS{1'b0}}} >> FRAC_BITS;
      return wide[WT_BITS-1:0];
   endfunction

endpackage

>>> rtl/vn2c_corner_hash.sv
// Five-stage integer hash of one lattice corner into a Q1.16 value.
`timescale 1ns / 1ps

module vn2c_corner_hash (
   input  logic                                 clock,
   input  vn2c_pkg::hash_en_type                en,
   input  logic [vn2c_pkg::LAT_W-1:0]           base,
   input  logic [vn2c_pkg::LAT_W-1:0]           offset,
   output logic signed [vn2c_pkg::NOISE_W-1:0]  value
);

   logic [vn2c_pkg::LAT_W-1:0] n_sum;
   logic [vn2c_pkg::LAT_W-1:0] mix_in;
   logic [vn2c_pkg::LAT_W-1:0] mix_ff;
   logic [vn2c_pkg::LAT_W-1:0] sq_in;
   logic [vn2c_pkg::LAT_W-1:0] sq_ff;
   logic [vn2c_pkg::LAT_W-1:0] mix_sq_ff;
   logic [vn2c_pkg::LAT_W-1:0] t_in;
   logic [vn2c_pkg::LAT_W-1:0] t_ff;
   logic [vn2c_pkg::LAT_W-1:0] mix_mul_ff;
   logic [vn2c_pkg::LAT_W-1:0] h_in;
   logic [vn2c_pkg::LAT_W-1:0] h_ff;
   logic signed [vn2c_pkg::NOISE_W-1:0] value_in;
   logic signed [vn2c_pkg::NOISE_W-1:0] value_ff;

   assign n_sum  = base + offset;
   assign mix_in = (n_sum << vn2c_pkg::HASH_XSHIFT) ^ n_sum;
   // keep only the low bits of each product; the 31-bit signal width drops the rest
   assign sq_in  = mix_ff * mix_ff;
   assign t_in   = sq_ff * vn2c_pkg::HASH_MUL + vn2c_pkg::HASH_ADD1;
   assign h_in   = mix_mul_ff * t_ff + vn2c_pkg::HASH_ADD2;
   assign value_in = vn2c_pkg::NOISE_ONE
                   - $signed({1'b0, h_ff[vn2c_pkg::LAT_W-1:vn2c_pkg::HASH_SHIFT]});

   always_ff @(posedge clock) begin
      if (en.mix) mix_ff <= mix_in;
      if (en.sq) begin
         sq_ff     <= sq_in;
         mix_sq_ff <= mix_ff;
      end
      if (en.mul) begin
         t_ff       <= t_in;
         mix_mul_ff <= mix_sq_ff;
      end
      if (en.fin) h_ff <= h_in;
      if (en.val) value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> rtl/value_noise_2d_cosine.sv
// An accepted request beat reaches rsp_valid through 11 register stages.
// Throughput: one point per cycle while rsp_ready is high; every stage holds independently,
// so bubbles close up and a new beat is taken whenever any stage ahead has room.
// Cost: the corner hash stages hold 31-bit multiplies (one per corner), the blend stages 19x18 multiplies.
// Reset clears the stage valid bits only; the weight table is a constant ROM.
`timescale 1ns / 1ps

module value_noise_2d_cosine (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [vn2c_pkg::COORD_W-1:0]         req_x_coord,
   input  logic signed [vn2c_pkg::COORD_W-1:0]         req_y_coord,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [vn2c_pkg::NOISE_W-1:0]         rsp_noise_value
);

   localparam int LAST   = vn2c_pkg::NUM_STAGES - 1;
   localparam int DIFF_W = vn2c_pkg::DIFF_W;

   logic [vn2c_pkg::NUM_STAGES-1:0] vld_ff;
   logic [vn2c_pkg::NUM_STAGES-1:0] vld_in;
   logic [vn2c_pkg::NUM_STAGES-1:0] adv;

   // split stage
   logic [vn2c_pkg::LAT_W-1:0]   ix_ff;
   logic [vn2c_pkg::LAT_W-1:0]   iy_ff;
   logic [vn2c_pkg::WT_BITS-1:0] idx_x_ff;
   logic [vn2c_pkg::WT_BITS-1:0] idx_y_ff;

   // base stage and weight carry lines
   logic [vn2c_pkg::LAT_W-1:0]    base_in;
   logic [vn2c_pkg::LAT_W-1:0]    base_ff;
   logic [vn2c_pkg::WEIGHT_W-1:0] wx_ff [vn2c_pkg::ST_BASE:vn2c_pkg::ST_VAL];
   logic [vn2c_pkg::WEIGHT_W-1:0] wy_ff [vn2c_pkg::ST_BASE:vn2c_pkg::ST_XBLEND];

   vn2c_pkg::hash_en_type hash_en;
   logic signed [vn2c_pkg::NOISE_W-1:0] v00;
   logic signed [vn2c_pkg::NOISE_W-1:0] v10;
   logic signed [vn2c_pkg::NOISE_W-1:0] v01;
   logic signed [vn2c_pkg::NOISE_W-1:0] v11;

   // blend stages
   logic signed [vn2c_pkg::DIFF_W-1:0]  dtop;
   logic signed [vn2c_pkg::DIFF_W-1:0]  dbot;
   logic signed [vn2c_pkg::PROD_W-1:0]  ptop_in;
   logic signed [vn2c_pkg::PROD_W-1:0]  pbot_in;
   logic signed [vn2c_pkg::PROD_W-1:0]  ptop_ff;
   logic signed [vn2c_pkg::PROD_W-1:0]  pbot_ff;
   logic signed [vn2c_pkg::NOISE_W-1:0] v00_ff;
   logic signed [vn2c_pkg::NOISE_W-1:0] v01_ff;
   logic signed [vn2c_pkg::PROD_W-1:0]  rtop;
   logic signed [vn2c_pkg::PROD_W-1:0]  rbot;
   logic signed [vn2c_pkg::NOISE_W-1:0] top_in;
   logic signed [vn2c_pkg::NOISE_W-1:0] bot_in;
   logic signed [vn2c_pkg::NOISE_W-1:0] top_ff;
   logic signed [vn2c_pkg::NOISE_W-1:0] bot_ff;
   logic signed [vn2c_pkg::DIFF_W-1:0]  dy;
   logic signed [vn2c_pkg::PROD_W-1:0]  py_in;
   logic signed [vn2c_pkg::PROD_W-1:0]  py_ff;
   logic signed [vn2c_pkg::NOISE_W-1:0] top_y_ff;
   logic signed [vn2c_pkg::PROD_W-1:0]  ry;
   logic signed [vn2c_pkg::NOISE_W-1:0] noise_in;
   logic signed [vn2c_pkg::NOISE_W-1:0] noise_ff;

   // a stage may load when it is empty or its contents move on this cycle
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[vn2c_pkg::ST_SPLIT];

   // split each coordinate into lattice point and table index
   always_ff @(posedge clock) begin
      if (adv[vn2c_pkg::ST_SPLIT]) begin
         ix_ff    <= vn2c_pkg::lattice_of(req_x_coord);
         iy_ff    <= vn2c_pkg::lattice_of(req_y_coord);
         idx_x_ff <= vn2c_pkg::weight_index(req_x_coord);
         idx_y_ff <= vn2c_pkg::weight_index(req_y_coord);
      end
   end

   // hash base and registered weight table reads
   assign base_in = ix_ff + iy_ff * vn2c_pkg::LATTICE_MUL;

   always_ff @(posedge clock) begin
      if (adv[vn2c_pkg::ST_BASE]) begin
         base_ff                  <= base_in;
         wx_ff[vn2c_pkg::ST_BASE] <= vn2c_pkg::WEIGHT_ROM[idx_x_ff];
         wy_ff[vn2c_pkg::ST_BASE] <= vn2c_pkg::WEIGHT_ROM[idx_y_ff];
      end
      for (int s = vn2c_pkg::ST_MIX; s <= vn2c_pkg::ST_VAL; s++) begin
         if (adv[s]) wx_ff[s] <= wx_ff[s-1];
      end
      for (int s = vn2c_pkg::ST_MIX; s <= vn2c_pkg::ST_XBLEND; s++) begin
         if (adv[s]) wy_ff[s] <= wy_ff[s-1];
      end
   end

   assign hash_en.mix = adv[vn2c_pkg::ST_MIX];
   assign hash_en.sq  = adv[vn2c_pkg::ST_SQ];
   assign hash_en.mul = adv[vn2c_pkg::ST_MUL];
   assign hash_en.fin = adv[vn2c_pkg::ST_FIN];
   assign hash_en.val = adv[vn2c_pkg::ST_VAL];

   vn2c_corner_hash u_hash00 (
      .clock  (clock),
      .en     (hash_en),
      .base   (base_ff),
      .offset (vn2c_pkg::OFS_X0Y0),
      .value  (v00)
   );

   vn2c_corner_hash u_hash10 (
      .clock  (clock),
      .en     (hash_en),
      .base   (base_ff),
      .offset (vn2c_pkg::OFS_X1Y0),
      .value  (v10)
   );

   vn2c_corner_hash u_hash01 (
      .clock  (clock),
      .en     (hash_en),
      .base   (base_ff),
      .offset (vn2c_pkg::OFS_X0Y1),
      .value  (v01)
   );

   vn2c_corner_hash u_hash11 (
      .clock  (clock),
      .en     (hash_en),
      .base   (base_ff),
      .offset (vn2c_pkg::OFS_X1Y1),
      .value  (v11)
   );

   // lerp as a + round((b - a) * w / 2^16), halves rounded up
   assign dtop    = DIFF_W'(v10) - DIFF_W'(v00);
   assign dbot    = DIFF_W'(v11) - DIFF_W'(v01);
   assign ptop_in = dtop * $signed({1'b0, wx_ff[vn2c_pkg::ST_VAL]});
   assign pbot_in = dbot * $signed({1'b0, wx_ff[vn2c_pkg::ST_VAL]});

   assign rtop   = (ptop_ff + vn2c_pkg::BLEND_ROUND) >>> vn2c_pkg::BLEND_SHIFT;
   assign rbot   = (pbot_ff + vn2c_pkg::BLEND_ROUND) >>> vn2c_pkg::BLEND_SHIFT;
   assign top_in = v00_ff + rtop[vn2c_pkg::NOISE_W-1:0];
   assign bot_in = v01_ff + rbot[vn2c_pkg::NOISE_W-1:0];

   assign dy    = DIFF_W'(bot_ff) - DIFF_W'(top_ff);
   assign py_in = dy * $signed({1'b0, wy_ff[vn2c_pkg::ST_XBLEND]});

   assign ry       = (py_ff + vn2c_pkg::BLEND_ROUND) >>> vn2c_pkg::BLEND_SHIFT;
   assign noise_in = top_y_ff + ry[vn2c_pkg::NOISE_W-1:0];

   always_ff @(posedge clock) begin
      if (adv[vn2c_pkg::ST_XPROD]) begin
         ptop_ff <= ptop_in;
         pbot_ff <= pbot_in;
         v00_ff  <= v00;
         v01_ff  <= v01;
      end
      if (adv[vn2c_pkg::ST_XBLEND]) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
      end
      if (adv[vn2c_pkg::ST_YPROD]) begin
         py_ff    <= py_in;
         top_y_ff <= top_ff;
      end
      if (adv[vn2c_pkg::ST_OUT]) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_valid       = vld_ff[LAST];
   assign rsp_noise_value = noise_ff;

`ifndef NO_ASSERTIONS
   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[vn2c_pkg::ST_SPLIT])
      else $error("accepted beat did not enter the first stage");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ready |-> !req_ready)
      else $error("request taken while the pipeline is full and stalled");

   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value >= -vn2c_pkg::NOISE_ONE)
                 && (rsp_noise_value <= vn2c_pkg::NOISE_ONE))
      else $error("noise value outside minus one to one");
`endif

endmodule

>>> tb/value_noise_2d_cosine_tb.sv
// Self-checking testbench for the 2D cosine-blended value noise pipeline.
`timescale 1ns / 1ps

module value_noise_2d_cosine_tb;

   localparam int             COORD_W       = vn2c_pkg::COORD_W;
   localparam int             NOISE_W       = vn2c_pkg::NOISE_W;
   localparam int             FRAC_BITS     = vn2c_pkg::FRAC_BITS;
   localparam int             WT_BITS       = vn2c_pkg::WT_BITS;
   localparam int             WT_SIZE       = vn2c_pkg::WT_SIZE;
   localparam int             RANDOM_POINTS = 1930;
   localparam int             STALL_LIMIT   = 2000;
   localparam int             DRAIN_CYCLES  = 20;
   localparam int             IDX_SHIFT     = FRAC_BITS - WT_BITS;
   localparam longint         UNIT_Q16      = 65536;
   localparam longint unsigned PI_Q30       = 64'd3373259426;
   localparam bit [31:0]      ROW_STRIDE    = 32'd57;
   localparam bit [31:0]      MIX_MUL       = 32'd60493;
   localparam bit [31:0]      MIX_ADD       = 32'd19990303;
   localparam bit [31:0]      MIX_OFFSET    = 32'd1376312589;
   localparam bit [31:0]      MIX_MASK      = 32'h7fff_ffff;

   typedef logic signed [NOISE_W-1:0] noise_type;

   typedef struct {
      bit [COORD_W-1:0] x;
      bit [COORD_W-1:0] y;
      bit               typed;
      noise_type        noise;
   } point_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [COORD_W-1:0]  req_x_coord = '0;
   logic signed [COORD_W-1:0]  req_y_coord = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [NOISE_W-1:0]  rsp_noise_value;

   int unsigned cos_weight_table [WT_SIZE];
   noise_type   pending_noise [$];
   int          points_sent = 0;
   int          values_checked = 0;
   int          mismatch_count = 0;
   bit          gaps_on = 1'b1;

   // the origin has zero fractions and picks weight zero, so it reads the bare corner hash
   point_row_type directed_rows [19] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, -18'sd18467},
      '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
      '{32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
      '{32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
      '{32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
      '{32'h0000_0001, 32'h0000_0001, 1'b0, '0},
      '{32'h0000_8000, 32'h0000_0000, 1'b0, '0},
      '{32'hffff_8000, 32'h0000_0000, 1'b0, '0},
      '{32'h0000_0000, 32'h0000_8000, 1'b0, '0},
      '{32'h0000_0000, 32'hffff_8000, 1'b0, '0},
      '{32'h7fff_0000, 32'h0000_0000, 1'b0, '0},
      '{32'h0000_0000, 32'h7fff_0000, 1'b0, '0},
      '{32'hffff_0000, 32'hffff_0000, 1'b0, '0},
      '{32'h0000_ffff, 32'hffff_0001, 1'b0, '0},
      '{32'hfffe_c000, 32'h0003_4000, 1'b0, '0},
      '{32'h0001_0000, 32'h0001_0000, 1'b0, '0},
      '{32'h1234_5678, 32'h9abc_def0, 1'b0, '0},
      '{32'h8000_ffff, 32'h7fff_0001, 1'b0, '0}
   };

   value_noise_2d_cosine DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // 65536*sin^2 of a quarter-wave step, sine from a Q30 Taylor series
   function automatic int unsigned sine_sq_weight(input longint unsigned k);
      longint unsigned phi;
      longint unsigned phi2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned s2;
      longint unsigned j;
      bit              sub;
      phi  = (PI_Q30 * k) / (2 * longint'(WT_SIZE));
      phi2 = (phi * phi) >> 30;
      term = phi;
      sum  = phi;
      sub  = 1'b1;
      for (j = 3; j <= 15; j += 2) begin
         term = ((term * phi2) >> 30) / ((j - 1) * j);
         if (sub) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         sub = ~sub;
      end
      s2 = (sum * sum) >> 30;
      return int'((s2 + 64'd8192) >> 14);
   endfunction

   // truncate toward zero; the weight follows the fraction magnitude
   function automatic void split_axis(input bit [31:0] raw, output bit [31:0] lat,
                                      output int unsigned w);
      bit [32:0]   mag;
      bit [31:0]   ip;
      bit [31:0]   fr;
      int unsigned idx;
      mag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
      ip  = 32'(mag >> FRAC_BITS);
      fr  = 32'(mag) & ((32'd1 << FRAC_BITS) - 32'd1);
      lat = raw[31] ? (32'd0 - ip) : ip;
      if (IDX_SHIFT >= 0) begin
         idx = fr >> IDX_SHIFT;
      end else begin
         idx = fr << (-IDX_SHIFT);
      end
      w = cos_weight_table[idx & (WT_SIZE - 1)];
   endfunction

   function automatic longint corner_value(input bit [31:0] ix, input bit [31:0] iy);
      bit [31:0] n;
      bit [31:0] h;
      n = ix + iy * ROW_STRIDE;
      n = (n << 13) ^ n;
      h = (n * (n * n * MIX_MUL + MIX_ADD) + MIX_OFFSET) & MIX_MASK;
      return UNIT_Q16 - longint'(h >> 14);
   endfunction

   // halves round up
   function automatic longint cos_blend(input longint a, input longint b, input int unsigned w);
      longint acc;
      acc = a * (UNIT_Q16 - longint'(w)) + b * longint'(w);
      return (acc + 32768) >>> 16;
   endfunction

   function automatic noise_type noise_at(input bit [31:0] x, input bit [31:0] y);
      bit [31:0]   ix;
      bit [31:0]   iy;
      int unsigned wx;
      int unsigned wy;
      longint      top;
      longint      bot;
      longint      mix;
      split_axis(x, ix, wx);
      split_axis(y, iy, wy);
      top = cos_blend(corner_value(ix, iy), corner_value(ix + 1, iy), wx);
      bot = cos_blend(corner_value(ix, iy + 1), corner_value(ix + 1, iy + 1), wx);
      mix = cos_blend(top, bot, wy);
      return noise_type'(mix[NOISE_W-1:0]);
   endfunction

   function automatic bit take_gap();
      return $urandom_range(99) < 15;
   endfunction

   // mostly small or lattice-aligned points, with full-range and wrap-edge ones mixed in
   function automatic bit [31:0] pick_coord();
      int unsigned sel;
      bit [31:0]   c;
      sel = $urandom_range(99);
      if (sel < 35) begin
         c = $urandom;
      end else if (sel < 65) begin
         c = 32'($urandom_range(0, 16 << FRAC_BITS)) - (32'd8 << FRAC_BITS);
      end else if (sel < 78) begin
         c = {16'($urandom), 16'h0000};
      end else if (sel < 90) begin
         c = 32'($urandom_range(0, 15)) << FRAC_BITS;
         c = c | ($urandom_range(1) ? 32'($urandom_range(1, 63))
                                    : 32'($urandom_range(16'hffc0, 16'hffff)));
         if ($urandom_range(1)) c = 32'd0 - c;
      end else begin
         c = $urandom_range(1) ? (32'h7ffe_0000 + 32'($urandom_range(0, 32'h1_ffff)))
                               : (32'h8000_0000 + 32'($urandom_range(0, 32'h1_ffff)));
      end
      return c;
   endfunction

   task automatic send_point(input bit [31:0] x, input bit [31:0] y, input bit typed,
                             input noise_type noise);
      if (gaps_on && take_gap()) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_noise.push_back(typed ? noise : noise_at(x, y));
      points_sent++;
   endtask

   // result side: random stalls, one long hold-off, one stretch always ready
   initial begin : drive_rsp_ready
      int rx_cycle;
      rx_cycle = 0;
      while (reset) @(posedge clock);
      forever begin
         if (rx_cycle >= 300 && rx_cycle < 450) begin
            rsp_ready <= 1'b0;
         end else if (rx_cycle >= 1200 && rx_cycle < 1800) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= !take_gap();
         end
         @(posedge clock);
         rx_cycle++;
      end
   end

   always @(posedge clock) begin : check_rsp
      noise_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_noise.size() == 0) begin
            $display("%0t: result beat with nothing pending, expected none, got %0d",
                     $time, rsp_noise_value);
            mismatch_count++;
         end else begin
            want = pending_noise.pop_front();
            values_checked++;
            if (rsp_noise_value !== want) begin
               $display("%0t: noise_value mismatch, expected %0d, got %0d",
                        $time, want, rsp_noise_value);
               mismatch_count++;
            end
         end
      end
   end

   // end the run once nothing has moved on either channel for too long
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("%0t: no beat accepted for %0d cycles, %0d results still pending",
               $time, STALL_LIMIT, pending_noise.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : run_points
      int i;
      for (i = 0; i < WT_SIZE; i++) begin
         if (2 * i <= WT_SIZE) begin
            cos_weight_table[i] = sine_sq_weight(longint'(i));
         end else begin
            cos_weight_table[i] = 32'(UNIT_Q16) - sine_sq_weight(longint'(WT_SIZE - i));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].typed,
                    directed_rows[r].noise);
      end

      for (i = 0; i < RANDOM_POINTS; i++) begin
         gaps_on = !(i >= 600 && i < 1100);
         // hold input until the pipeline has emptied
         if (i == 1300) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_noise.size() != 0);
         end
         send_point(pick_coord(), pick_coord(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_noise.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d points (axis extremes, lattice wrap, negative fractions, random)",
               points_sent);
      $display("Checked %0d noise values, %0d mismatches", values_checked, mismatch_count);
      if (mismatch_count == 0 && pending_noise.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
